FILE: hdl/box_filter_sliding_window_core_defines.svh
// Assertion macros shared by the box filter RTL files.
`ifndef BOX_FILTER_SLIDING_WINDOW_CORE_DEFINES_SVH
`define BOX_FILTER_SLIDING_WINDOW_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold while out of reset.
`define BFSW_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("box filter assertion failed");

// When the trigger holds, the consequence holds in the next cycle.
`define BFSW_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("box filter assertion failed");

`else

`define BFSW_ASSERT_NEVER(label, clk, rst_n, cond)
`define BFSW_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

FILE: hdl/bfsw_pkg.sv
// Package with the types and constants of the box filter.
`default_nettype none

package bfsw_pkg;

  // Default sizing of the window and of the line store.
  localparam int BFSW_MAX_WIDTH = 1024;
  localparam int BFSW_MAX_K     = 32;
  localparam int BFSW_MAX_ROWS  = 4096;

  // Field widths.
  localparam int BFSW_PIX_W   = 8;
  localparam int BFSW_OW_W    = 11;
  localparam int BFSW_OH_W    = 13;
  localparam int BFSW_K_W     = 6;
  localparam int BFSW_PW_W    = 11;
  localparam int BFSW_SCALE_W = 16;

  // Internal widths: column and row counters, clamped kernel size.
  localparam int BFSW_COL_W    = 12;
  localparam int BFSW_ROW_W    = 13;
  localparam int BFSW_KCLAMP_W = 7;

  // Configuration port.
  localparam int BFSW_CFG_IDX_W  = 3;
  localparam int BFSW_CFG_DATA_W = 16;

  localparam logic [BFSW_CFG_IDX_W-1:0] CFG_OUT_WIDTH    = 3'd0;
  localparam logic [BFSW_CFG_IDX_W-1:0] CFG_OUT_HEIGHT   = 3'd1;
  localparam logic [BFSW_CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 3'd2;
  localparam logic [BFSW_CFG_IDX_W-1:0] CFG_PADDED_WIDTH = 3'd3;
  localparam logic [BFSW_CFG_IDX_W-1:0] CFG_SCALE        = 3'd4;

  // Register values after reset.
  localparam logic [BFSW_OW_W-1:0]    RST_OUT_WIDTH    = 11'd1024;
  localparam logic [BFSW_OH_W-1:0]    RST_OUT_HEIGHT   = 13'd1024;
  localparam logic [BFSW_K_W-1:0]     RST_KERNEL_SIZE  = 6'd3;
  localparam logic [BFSW_PW_W-1:0]    RST_PADDED_WIDTH = 11'd1026;
  localparam logic [BFSW_SCALE_W-1:0] RST_SCALE        = 16'd7282;

  // Output queue.
  localparam int BFSW_OQ_DEPTH = 4;
  localparam int BFSW_OQ_PTR_W = 2;
  localparam int BFSW_OQ_CNT_W = 3;

  typedef struct packed {
    logic [BFSW_PIX_W-1:0] pixel;
    logic                  end_of_row;
    logic                  end_of_frame;
  } bfsw_result_t;

endpackage

`default_nettype wire

FILE: hdl/box_filter_sliding_window_core.sv
// Top level of the streaming K-by-K box filter built on running sums.
//
// The block takes an already padded 8-bit image in raster order, one pixel per
// request on the in_ channel, and returns the scaled K-by-K window sums on the
// out_ channel, with marks on the last pixel of each row and of the frame.
// A request moves when its valid is high and its stall is low.
// Configuration registers are written through the cfg_ channel, whose ready
// is always high; they should be changed only while no request is in flight.
//
// One input request is taken every clock while in_stall is low. Each result
// passes in order through the read of the column-sum and line-store RAMs, the
// column-sum update and the scale multiplier on its way to the output. A
// four-entry result queue sits in front of the output; in_stall rises only
// when the queue plus the two results still in the pipeline would fill it, so
// a stalled receiver holds back the input after at most a few requests and
// nothing is lost.
//
// Reset clears the counters and the handshake state and loads the default
// configuration. The line store and the column sums are not cleared: the first
// row of each frame overwrites the column sums, and line-store rows are read
// only after they were written in the same frame, so there is no clearing pass.
`default_nettype none

`include "box_filter_sliding_window_core_defines.svh"

module box_filter_sliding_window_core
  import bfsw_pkg::*;
#(
  parameter int MAX_WIDTH = BFSW_MAX_WIDTH,
  parameter int MAX_K     = BFSW_MAX_K
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [BFSW_PIX_W-1:0]       in_pixel_in,

  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [BFSW_PIX_W-1:0]            out_pixel_out,
  output logic                             out_end_of_row,
  output logic                             out_end_of_frame,

  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [BFSW_CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [BFSW_CFG_DATA_W-1:0]  cfg_data
);

  // Column index width, window slot width, sum widths.
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int HSW   = $clog2(MAX_K * 255 + 1);
  localparam int CSW   = $clog2(MAX_K * MAX_K * 255 + 1);
  localparam int LS_DEPTH = MAX_K * (2 ** XW);
  localparam int LSAW  = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
  localparam int SW    = KW + 2;
  localparam int PIX_MAX = 255;

  localparam int CW  = BFSW_COL_W;
  localparam int RW  = BFSW_ROW_W;
  localparam int KCW = BFSW_KCLAMP_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BFSW_OW_W-1:0]    out_width_r;
  logic [BFSW_OH_W-1:0]    out_height_r;
  logic [BFSW_K_W-1:0]     kernel_size_r;
  logic [BFSW_PW_W-1:0]    padded_width_r;
  logic [BFSW_SCALE_W-1:0] scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r    <= RST_OUT_WIDTH;
      out_height_r   <= RST_OUT_HEIGHT;
      kernel_size_r  <= RST_KERNEL_SIZE;
      padded_width_r <= RST_PADDED_WIDTH;
      scale_r        <= RST_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OUT_WIDTH:    out_width_r    <= cfg_data[BFSW_OW_W-1:0];
        CFG_OUT_HEIGHT:   out_height_r   <= cfg_data[BFSW_OH_W-1:0];
        CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[BFSW_K_W-1:0];
        CFG_PADDED_WIDTH: padded_width_r <= cfg_data[BFSW_PW_W-1:0];
        CFG_SCALE:        scale_r        <= cfg_data[BFSW_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry derived from the registers.
  logic [KCW-1:0] k_a;
  logic [CW-1:0]  w_a, used_a, stride_a, km1_col_a;
  logic [RW-1:0]  h_a, rows_a, km1_row_a;

  always_comb begin
    if (kernel_size_r == '0) begin
      k_a = KCW'(1);
    end else if (int'(kernel_size_r) > MAX_K) begin
      k_a = KCW'(MAX_K);
    end else begin
      k_a = KCW'(kernel_size_r);
    end

    if (out_width_r == '0) begin
      w_a = CW'(1);
    end else if (int'(out_width_r) > MAX_WIDTH) begin
      w_a = CW'(MAX_WIDTH);
    end else begin
      w_a = CW'(out_width_r);
    end

    if (out_height_r == '0) begin
      h_a = RW'(1);
    end else if (int'(out_height_r) > BFSW_MAX_ROWS) begin
      h_a = RW'(BFSW_MAX_ROWS);
    end else begin
      h_a = RW'(out_height_r);
    end

    km1_col_a = CW'(k_a) - 1'b1;
    km1_row_a = RW'(k_a) - 1'b1;
    used_a    = w_a + km1_col_a;
    stride_a  = (CW'(padded_width_r) < used_a) ? used_a : CW'(padded_width_r);
    rows_a    = h_a + km1_row_a;
  end

  // ---------------------------------------------------------------------------
  // Input stage: counters, pixel window and horizontal running sum
  // ---------------------------------------------------------------------------
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [KW-1:0]         slot_r, slot_nxt;
  logic [BFSW_PIX_W-1:0] taps_r [MAX_K];
  logic [HSW-1:0]        hsum_r, hsum_a;

  logic                  accept;
  logic                  in_cols_a, upd_a, emit_a, eor_a, eof_a, sub_a;
  logic [CW-1:0]         x_a;
  logic [RW-1:0]         y_a;
  logic [BFSW_PIX_W-1:0] tap_a;
  logic [SW-1:0]         rslot_sum_a;
  logic [KW-1:0]         rslot_a;
  logic [XW-1:0]         xi_a;
  logic [LSAW-1:0]       ls_wa_a, ls_ra_a;

  assign accept = in_valid && !in_stall;

  always_comb begin
    in_cols_a = col_r < used_a;
    upd_a     = in_cols_a && (col_r >= km1_col_a);
    x_a       = col_r - km1_col_a;
    y_a       = row_r - km1_row_a;
    emit_a    = upd_a && (row_r >= km1_row_a);
    eor_a     = x_a == (w_a - 1'b1);
    eof_a     = eor_a && (y_a == (h_a - 1'b1));
    sub_a     = row_r >= RW'(k_a);
    xi_a      = XW'(x_a);

    // The pixel that leaves the window is the one K columns back in this row.
    tap_a  = taps_r[KW'(k_a - 1'b1)];
    hsum_a = ((col_r == '0) ? '0 : hsum_r) + HSW'(in_pixel_in);
    if (col_r >= CW'(k_a)) begin
      hsum_a = hsum_a - HSW'(tap_a);
    end

    // Line-store slot of row r-K, that is the current slot minus K, wrapped.
    rslot_sum_a = SW'(slot_r) + SW'(MAX_K) - SW'(k_a);
    if (rslot_sum_a >= SW'(MAX_K)) begin
      rslot_sum_a = rslot_sum_a - SW'(MAX_K);
    end
    rslot_a = KW'(rslot_sum_a);

    ls_wa_a = LSAW'({slot_r, xi_a});
    ls_ra_a = LSAW'({rslot_a, xi_a});

    // Raster counters; the slot counter follows the row counter modulo MAX_K.
    col_nxt  = col_r + 1'b1;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (col_nxt >= stride_a) begin
      col_nxt = '0;
      row_nxt = row_r + 1'b1;
      if (row_nxt >= rows_a) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else if (slot_r == KW'(MAX_K - 1)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_cols_a) begin
      hsum_r    <= hsum_a;
      taps_r[0] <= in_pixel_in;
      for (int i = 1; i < MAX_K; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Update stage: column sums and line store
  // ---------------------------------------------------------------------------
  logic              b_upd_r, b_emit_r;
  logic              b_r0_r, b_sub_r, b_eor_r, b_eof_r;
  logic [XW-1:0]     b_x_r;
  logic [LSAW-1:0]   b_ls_wa_r, b_ls_ra_r;
  logic [HSW-1:0]    b_hsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_upd_r  <= 1'b0;
      b_emit_r <= 1'b0;
    end else begin
      b_upd_r  <= accept && upd_a;
      b_emit_r <= accept && emit_a;
    end
  end

  always_ff @(posedge clk) begin
    b_r0_r    <= row_r == '0;
    b_sub_r   <= sub_a;
    b_eor_r   <= eor_a;
    b_eof_r   <= eof_a;
    b_x_r     <= xi_a;
    b_ls_wa_r <= ls_wa_a;
    b_ls_ra_r <= ls_ra_a;
    b_hsum_r  <= hsum_a;
  end

  logic [CSW-1:0] cs_rd_data;
  logic [HSW-1:0] ls_rd_data;
  logic [CSW-1:0] cs_old_b, cs_new_b;
  logic [HSW-1:0] ls_old_b;

  // The RAM read registered at the last edge missed the write made at that
  // same edge, so that one write is forwarded.
  logic           wr_fwd_r;
  logic [XW-1:0]  cs_wa_r;
  logic [CSW-1:0] cs_wd_r;
  logic [LSAW-1:0] ls_wa_r;
  logic [HSW-1:0] ls_wd_r;

  always_comb begin
    cs_old_b = (wr_fwd_r && cs_wa_r == b_x_r) ? cs_wd_r : cs_rd_data;
    ls_old_b = (wr_fwd_r && ls_wa_r == b_ls_ra_r) ? ls_wd_r : ls_rd_data;
    if (b_r0_r) begin
      cs_new_b = CSW'(b_hsum_r);
    end else begin
      cs_new_b = cs_old_b + CSW'(b_hsum_r) - (b_sub_r ? CSW'(ls_old_b) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_fwd_r <= 1'b0;
    end else begin
      wr_fwd_r <= b_upd_r;
    end
  end

  always_ff @(posedge clk) begin
    cs_wa_r <= b_x_r;
    cs_wd_r <= cs_new_b;
    ls_wa_r <= b_ls_wa_r;
    ls_wd_r <= b_hsum_r;
  end

  bfsw_ram #(
    .WIDTH (CSW),
    .DEPTH (MAX_WIDTH)
  ) u_colsum_ram (
    .clk     (clk),
    .wr_en   (b_upd_r),
    .wr_addr (b_x_r),
    .wr_data (cs_new_b),
    .rd_addr (xi_a),
    .rd_data (cs_rd_data)
  );

  bfsw_ram #(
    .WIDTH (HSW),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (b_upd_r),
    .wr_addr (b_ls_wa_r),
    .wr_data (b_hsum_r),
    .rd_addr (ls_ra_a),
    .rd_data (ls_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Scale stage: multiply by the Q0.16 scale, truncate and saturate
  // ---------------------------------------------------------------------------
  logic           c_emit_r, c_eor_r, c_eof_r;
  logic [CSW-1:0] c_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_emit_r <= 1'b0;
    end else begin
      c_emit_r <= b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    c_sum_r <= cs_new_b;
    c_eor_r <= b_eor_r;
    c_eof_r <= b_eof_r;
  end

  logic [CSW+BFSW_SCALE_W-1:0] prod_c;
  logic [CSW-1:0]              scaled_c;
  bfsw_result_t                res_c;

  always_comb begin
    prod_c   = (CSW + BFSW_SCALE_W)'(c_sum_r) * (CSW + BFSW_SCALE_W)'(scale_r);
    scaled_c = prod_c[CSW+BFSW_SCALE_W-1:BFSW_SCALE_W];
    res_c.pixel        = (scaled_c > CSW'(PIX_MAX)) ? BFSW_PIX_W'(PIX_MAX)
                                                    : scaled_c[BFSW_PIX_W-1:0];
    res_c.end_of_row   = c_eor_r;
    res_c.end_of_frame = c_eof_r;
  end

  // ---------------------------------------------------------------------------
  // Output queue and flow control
  // ---------------------------------------------------------------------------
  bfsw_result_t               head;
  logic [BFSW_OQ_CNT_W-1:0]   oq_count;
  logic                       pop;

  assign out_valid = oq_count != '0;
  assign pop       = out_valid && !out_stall;

  bfsw_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (c_emit_r),
    .push_data (res_c),
    .pop       (pop),
    .head      (head),
    .count     (oq_count)
  );

  assign out_pixel_out    = head.pixel;
  assign out_end_of_row   = head.end_of_row;
  assign out_end_of_frame = head.end_of_frame;

  // Results already queued plus those still in the pipeline must leave room
  // for the one that the next accepted pixel may cause.
  assign in_stall = (int'(oq_count) + int'(b_emit_r) + int'(c_emit_r)) >= BFSW_OQ_DEPTH;

  `BFSW_ASSERT_NEVER(a_emit_needs_update, clk, rst_n, b_emit_r && !b_upd_r)
  `BFSW_ASSERT_NEXT(a_emit_reaches_scale, clk, rst_n, b_emit_r, c_emit_r)
  `BFSW_ASSERT_NEXT(a_fwd_follows_write, clk, rst_n, b_upd_r, wr_fwd_r && cs_wa_r == $past(b_x_r))

endmodule

`default_nettype wire

FILE: hdl/bfsw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bfsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // The read returns the contents before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/bfsw_out_queue.sv
// Small result queue that decouples the filter pipeline from the output stall.
`default_nettype none

`include "box_filter_sliding_window_core_defines.svh"

module bfsw_out_queue
  import bfsw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire bfsw_result_t             push_data,
  input  wire logic                     pop,
  output bfsw_result_t                  head,
  output logic [BFSW_OQ_CNT_W-1:0]      count
);

  bfsw_result_t               entries_r [BFSW_OQ_DEPTH];
  logic [BFSW_OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [BFSW_OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [BFSW_OQ_CNT_W-1:0]   count_r, count_nxt;

  localparam logic [BFSW_OQ_PTR_W-1:0] LAST_PTR = BFSW_OQ_PTR_W'(BFSW_OQ_DEPTH - 1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entries_r[rd_ptr_r];
  assign count = count_r;

  `BFSW_ASSERT_NEVER(q_no_overflow, clk, rst_n, push && !pop && count_r == BFSW_OQ_CNT_W'(BFSW_OQ_DEPTH))
  `BFSW_ASSERT_NEVER(q_no_underflow, clk, rst_n, pop && count_r == '0)
  `BFSW_ASSERT_NEXT(q_pop_drains, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

`default_nettype wire
